[rtl/jpeg_frame_size_check_assert.svh]
// assertion macros shared by the frame size check modules
// no dependencies; assertions compile out under SYNTHESIS
`ifndef JPEG_FRAME_SIZE_CHECK_ASSERT_SVH
`define JPEG_FRAME_SIZE_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
`define JFSC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jfsc assertion failed");
`define JFSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jfsc assertion failed");
`define JFSC_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("jfsc assertion failed");
`else
`define JFSC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define JFSC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define JFSC_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

[rtl/jfsc_pkg.sv]
// shared types and constants of the jpeg frame size check
// no dependencies
package jfsc_pkg;

   localparam logic [7:0] MARKER_NUL      = 8'h00;
   localparam logic [7:0] MARKER_TEM      = 8'h01;
   localparam logic [7:0] MARKER_SOF_LO   = 8'hC0;
   localparam logic [7:0] MARKER_DHT      = 8'hC4;
   localparam logic [7:0] MARKER_JPG      = 8'hC8;
   localparam logic [7:0] MARKER_DAC      = 8'hCC;
   localparam logic [7:0] MARKER_SOF_HI   = 8'hCF;
   localparam logic [7:0] MARKER_RST_LO   = 8'hD0;
   localparam logic [7:0] MARKER_RST_HI   = 8'hD7;
   localparam logic [7:0] MARKER_SOI      = 8'hD8;
   localparam logic [7:0] MARKER_EOI      = 8'hD9;
   localparam logic [7:0] MARKER_SOS      = 8'hDA;
   localparam logic [7:0] MARKER_FILL     = 8'hFF;

   localparam logic [7:0] CSR_EXPECTED_WIDTH  = 8'd0;
   localparam logic [7:0] CSR_EXPECTED_HEIGHT = 8'd1;

   localparam logic [15:0] EXPECTED_WIDTH_RESET  = 16'd7360;
   localparam logic [15:0] EXPECTED_HEIGHT_RESET = 16'd4912;

   localparam logic [1:0] VERDICT_MATCH    = 2'd0;
   localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
   localparam logic [1:0] VERDICT_BAD      = 2'd2;

   typedef struct packed {
      logic [7:0] value;
      logic       last_byte;
      logic       is_fill;
      logic       is_soi;
      logic       is_eoi;
      logic       is_bad_code;
      logic       is_standalone;
      logic       is_frame_code;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

[rtl/jfsc_front.sv]
// front end: accepts input words and classifies the marker code they carry
// depends on jfsc_pkg
module jfsc_front (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_byte_value,
   input  logic                      req_last_byte,
   input  jfsc_pkg::queue_status_type q_status,
   output logic                      push,
   output jfsc_pkg::item_type        push_item
);

   logic is_rst;
   logic is_sof_range;

   assign req_ready = !q_status.full;
   assign push      = req_valid && !q_status.full;

   assign is_rst = (req_byte_value >= jfsc_pkg::MARKER_RST_LO) &&
                   (req_byte_value <= jfsc_pkg::MARKER_RST_HI);
   assign is_sof_range = (req_byte_value >= jfsc_pkg::MARKER_SOF_LO) &&
                         (req_byte_value <= jfsc_pkg::MARKER_SOF_HI);

   always_comb begin
      push_item.value         = req_byte_value;
      push_item.last_byte     = req_last_byte;
      push_item.is_fill       = req_byte_value == jfsc_pkg::MARKER_FILL;
      push_item.is_soi        = req_byte_value == jfsc_pkg::MARKER_SOI;
      push_item.is_eoi        = req_byte_value == jfsc_pkg::MARKER_EOI;
      push_item.is_bad_code   = (req_byte_value == jfsc_pkg::MARKER_NUL) ||
                                (req_byte_value == jfsc_pkg::MARKER_EOI) ||
                                (req_byte_value == jfsc_pkg::MARKER_SOS);
      push_item.is_standalone = (req_byte_value == jfsc_pkg::MARKER_TEM) || is_rst;
      push_item.is_frame_code = is_sof_range &&
                                (req_byte_value != jfsc_pkg::MARKER_DHT) &&
                                (req_byte_value != jfsc_pkg::MARKER_JPG) &&
                                (req_byte_value != jfsc_pkg::MARKER_DAC);
   end

endmodule

[rtl/jfsc_queue.sv]
// two-entry queue of classified words between front and back
// depends on jfsc_pkg and the assertion macro header
`include "jpeg_frame_size_check_assert.svh"
module jfsc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  jfsc_pkg::item_type         push_item,
   input  logic                       pop,
   output jfsc_pkg::item_type         head_item,
   output jfsc_pkg::queue_status_type q_status
);

   jfsc_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign head_item      = entry_ff[rd_ptr_ff];
   assign q_status.empty = count_ff == 2'd0;
   assign q_status.full  = count_ff == 2'd2;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `JFSC_ASSERT_NEVER(a_no_push_full, clock, reset, push && q_status.full)
   `JFSC_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && q_status.empty)
   `JFSC_ASSERT_NEVER(a_count_range, clock, reset, count_ff == 2'd3)

endmodule

[rtl/jfsc_back.sv]
// back end: marker segment parser, frame header capture and result register
// depends on jfsc_pkg and the assertion macro header
`include "jpeg_frame_size_check_assert.svh"
module jfsc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  jfsc_pkg::item_type         head_item,
   input  jfsc_pkg::queue_status_type q_status,
   output logic                       pop,
   input  logic [15:0]                expected_width,
   input  logic [15:0]                expected_height,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_verdict,
   output logic [15:0]                rsp_frame_width,
   output logic [15:0]                rsp_frame_height
);

   typedef enum logic [3:0] {
      PH_SOI_HI,
      PH_SOI_LO,
      PH_SEG_FF,
      PH_CODE,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_SOF_LEN_HI,
      PH_SOF_LEN_LO,
      PH_SKIP,
      PH_SOF_BODY
   } phase_type;

   typedef enum logic [1:0] {
      DEC_NONE,
      DEC_FRAME,
      DEC_BAD
   } decision_type;

   phase_type    phase_ff, phase_in;
   decision_type dec_ff, dec_in;
   logic [15:0]  left_ff, left_in;
   logic [7:0]   len_hi_ff, len_hi_in;
   logic [2:0]   sof_off_ff, sof_off_in;
   logic [15:0]  cap_w_ff, cap_w_in;
   logic [15:0]  cap_h_ff, cap_h_in;
   logic         prev_fill_ff, prev_fill_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [1:0]   verdict_ff, verdict_in;
   logic [15:0]  width_ff, width_in;
   logic [15:0]  height_ff, height_in;

   logic        out_free;
   logic [15:0] seg_len;
   logic [15:0] left_dec;
   logic        eoi;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = !q_status.empty && (!head_item.last_byte || out_free);
   assign seg_len  = {len_hi_ff, head_item.value};
   assign left_dec = left_ff - 16'd1;
   assign eoi      = prev_fill_ff && head_item.is_eoi;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = verdict_ff;
   assign rsp_frame_width  = width_ff;
   assign rsp_frame_height = height_ff;

   always_comb begin
      phase_in     = phase_ff;
      dec_in       = dec_ff;
      left_in      = left_ff;
      len_hi_in    = len_hi_ff;
      sof_off_in   = sof_off_ff;
      cap_w_in     = cap_w_ff;
      cap_h_in     = cap_h_ff;
      prev_fill_in = prev_fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      verdict_in   = verdict_ff;
      width_in     = width_ff;
      height_in    = height_ff;

      if (pop) begin
         if (dec_ff == DEC_NONE) begin
            unique case (phase_ff)
               PH_SOI_HI: begin
                  if (head_item.is_fill) phase_in = PH_SOI_LO;
                  else dec_in = DEC_BAD;
               end
               PH_SOI_LO: begin
                  if (head_item.is_soi) phase_in = PH_SEG_FF;
                  else dec_in = DEC_BAD;
               end
               PH_SEG_FF: begin
                  if (head_item.is_fill) phase_in = PH_CODE;
                  else dec_in = DEC_BAD;
               end
               PH_CODE: begin
                  priority if (head_item.is_fill) begin
                     phase_in = PH_CODE;
                  end else if (head_item.is_bad_code) begin
                     dec_in = DEC_BAD;
                  end else if (head_item.is_standalone) begin
                     phase_in = PH_SEG_FF;
                  end else if (head_item.is_frame_code) begin
                     phase_in = PH_SOF_LEN_HI;
                  end else begin
                     phase_in = PH_LEN_HI;
                  end
               end
               PH_LEN_HI: begin
                  len_hi_in = head_item.value;
                  phase_in  = PH_LEN_LO;
               end
               PH_SOF_LEN_HI: begin
                  len_hi_in = head_item.value;
                  phase_in  = PH_SOF_LEN_LO;
               end
               PH_LEN_LO: begin
                  priority if (seg_len < 16'd2) begin
                     dec_in = DEC_BAD;
                  end else if (seg_len == 16'd2) begin
                     phase_in = PH_SEG_FF;
                  end else begin
                     left_in  = seg_len - 16'd2;
                     phase_in = PH_SKIP;
                  end
               end
               PH_SOF_LEN_LO: begin
                  if (seg_len < 16'd7) begin
                     dec_in = DEC_BAD;
                  end else begin
                     left_in    = seg_len - 16'd2;
                     sof_off_in = 3'd0;
                     phase_in   = PH_SOF_BODY;
                  end
               end
               PH_SKIP: begin
                  left_in = left_dec;
                  if (left_dec == 16'd0) phase_in = PH_SEG_FF;
               end
               PH_SOF_BODY: begin
                  unique case (sof_off_ff)
                     3'd1: cap_h_in = {head_item.value, 8'd0};
                     3'd2: cap_h_in = {cap_h_ff[15:8], head_item.value};
                     3'd3: cap_w_in = {head_item.value, 8'd0};
                     3'd4: cap_w_in = {cap_w_ff[15:8], head_item.value};
                     default: begin
                     end
                  endcase
                  if (sof_off_ff != 3'd7) sof_off_in = sof_off_ff + 3'd1;
                  left_in = left_dec;
                  if (left_dec == 16'd0) dec_in = DEC_FRAME;
               end
               default: dec_in = DEC_BAD;
            endcase
         end

         if (!head_item.last_byte) begin
            prev_fill_in = head_item.is_fill;
         end else begin
            rsp_valid_in = 1'b1;
            if (dec_in == DEC_FRAME) begin
               width_in  = cap_w_in;
               height_in = cap_h_in;
               priority if (!eoi) begin
                  verdict_in = jfsc_pkg::VERDICT_BAD;
               end else if (cap_w_in == expected_width && cap_h_in == expected_height) begin
                  verdict_in = jfsc_pkg::VERDICT_MATCH;
               end else begin
                  verdict_in = jfsc_pkg::VERDICT_MISMATCH;
               end
            end else begin
               width_in   = 16'd0;
               height_in  = 16'd0;
               verdict_in = jfsc_pkg::VERDICT_BAD;
            end
            phase_in     = PH_SOI_HI;
            dec_in       = DEC_NONE;
            left_in      = 16'd0;
            len_hi_in    = 8'd0;
            sof_off_in   = 3'd0;
            cap_w_in     = 16'd0;
            cap_h_in     = 16'd0;
            prev_fill_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SOI_HI;
         dec_ff       <= DEC_NONE;
         left_ff      <= 16'd0;
         len_hi_ff    <= 8'd0;
         sof_off_ff   <= 3'd0;
         cap_w_ff     <= 16'd0;
         cap_h_ff     <= 16'd0;
         prev_fill_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         dec_ff       <= dec_in;
         left_ff      <= left_in;
         len_hi_ff    <= len_hi_in;
         sof_off_ff   <= sof_off_in;
         cap_w_ff     <= cap_w_in;
         cap_h_ff     <= cap_h_in;
         prev_fill_ff <= prev_fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      verdict_ff <= verdict_in;
      width_ff   <= width_in;
      height_ff  <= height_in;
   end

   `JFSC_ASSERT_SAME(a_last_pop_room, clock, reset, pop && head_item.last_byte, out_free)
   `JFSC_ASSERT_NEXT(a_last_gives_rsp, clock, reset, pop && head_item.last_byte, rsp_valid_ff)
   `JFSC_ASSERT_NEXT(a_last_restarts, clock, reset, pop && head_item.last_byte,
                     phase_ff == PH_SOI_HI && dec_ff == DEC_NONE)
   `JFSC_ASSERT_SAME(a_verdict_code, clock, reset, rsp_valid_ff,
                     verdict_ff == jfsc_pkg::VERDICT_MATCH ||
                     verdict_ff == jfsc_pkg::VERDICT_MISMATCH ||
                     verdict_ff == jfsc_pkg::VERDICT_BAD)
   `JFSC_ASSERT_SAME(a_match_size, clock, reset,
                     rsp_valid_ff && verdict_ff == jfsc_pkg::VERDICT_MATCH,
                     width_ff == expected_width && height_ff == expected_height)

endmodule

[rtl/jpeg_frame_size_check.sv]
// jpeg frame size check: top level with configuration registers
// depends on jfsc_pkg, jfsc_front, jfsc_queue and jfsc_back
//
// The file streams in one word per byte on req_ (req_byte_value, with
// req_last_byte on the final byte). The block checks the SOI marker, walks
// the marker segments and captures height and width from the first frame
// header segment. On the final byte it returns one word on rsp_: verdict
// (match, mismatch, or bad: malformed or no frame header) and captured size.
// Other bytes return nothing. The next byte starts a new file.
// csr_ writes expected_width (index 0) and expected_height (index 1); other
// indexes are dropped. csr_ready is always high.
// Throughput is one byte per cycle unless a stalled rsp_ backs up; the
// parser takes one byte per cycle. A byte passes the classifier into a
// two-entry queue; the result word is registered as the final byte pops.
// A stalled rsp_ holds its word; bytes keep flowing until the final byte of
// the next file reaches the parser, then the queue fills and req_ready drops.
// Synchronous reset clears the parser and queue and restores the expected
// size to 7360 by 4912.
module jpeg_frame_size_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   output logic [15:0] rsp_frame_width,
   output logic [15:0] rsp_frame_height,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] exp_width_ff, exp_width_in;
   logic [15:0] exp_height_ff, exp_height_in;

   logic                       push;
   logic                       pop;
   jfsc_pkg::item_type         push_item;
   jfsc_pkg::item_type         head_item;
   jfsc_pkg::queue_status_type q_status;

   assign csr_ready = 1'b1;

   always_comb begin
      exp_width_in  = exp_width_ff;
      exp_height_in = exp_height_ff;
      if (csr_valid) begin
         if (csr_index == jfsc_pkg::CSR_EXPECTED_WIDTH) exp_width_in = csr_data;
         if (csr_index == jfsc_pkg::CSR_EXPECTED_HEIGHT) exp_height_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_width_ff  <= jfsc_pkg::EXPECTED_WIDTH_RESET;
         exp_height_ff <= jfsc_pkg::EXPECTED_HEIGHT_RESET;
      end else begin
         exp_width_ff  <= exp_width_in;
         exp_height_ff <= exp_height_in;
      end
   end

   jfsc_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .req_last_byte  (req_last_byte),
      .q_status       (q_status),
      .push           (push),
      .push_item      (push_item)
   );

   jfsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   jfsc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_item        (head_item),
      .q_status         (q_status),
      .pop              (pop),
      .expected_width   (exp_width_ff),
      .expected_height  (exp_height_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_verdict      (rsp_verdict),
      .rsp_frame_width  (rsp_frame_width),
      .rsp_frame_height (rsp_frame_height)
   );

endmodule
